>>> rtl/utf8_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Concurrent assertion shorthands, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define USD_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("utf8_stream_decoder: assertion failed");
`define USD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("utf8_stream_decoder: assertion failed");
`else
`define USD_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define USD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

>>> rtl/usd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Payload types, decoder constants and the result run descriptor.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [20:0] MAX_SCALAR     = 21'h10FFFF;
    localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
    localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
    localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;
    localparam logic [20:0] SURROGATE_LO   = 21'h00D800;
    localparam logic [20:0] SURROGATE_HI   = 21'h00DFFF;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD_LO     = 8'hC0;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD_LIMIT  = 8'hF8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } usd_in_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic        malformed;
        logic        last_of_run;
    } usd_out_t;

    // replacements first, then an optional decoded scalar
    typedef struct packed {
        logic [2:0]  reps;
        logic        has_valid;
        logic [20:0] code_point;
        logic [2:0]  byte_count;
    } usd_run_t;

endpackage

>>> rtl/usd_stream_if.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channel interface
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface usd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/usd_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder input stage and decode
// Registers the input byte, tracks the open sequence and builds a result run.
// ----------------------------------------------------------------------------
module usd_decode (
    input  logic             clk,
    input  logic             rst_n,
    usd_stream_if.sink       byte_stream,
    input  logic             run_free,
    output logic             run_load,
    output usd_pkg::usd_run_t run_desc
);
    import usd_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eot_reg;

    logic       open_reg, open_next;
    logic [7:0] lead_reg, lead_next;
    logic [1:0] gathered_reg, gathered_next;
    logic [5:0] cont_reg [2];
    logic [5:0] cont_next [2];

    logic        advance;
    logic        desc_empty;
    logic        is_cont;
    logic        consumed;
    logic [1:0]  need;
    logic        completes;
    logic [20:0] full_cp;
    logic        cp_ok;
    usd_run_t    desc;

    assign is_cont = (s1_byte_reg[7:6] == 2'b10);

    always_comb
    begin
        if (lead_reg < LEAD3_LO)
        begin
            need = 2'd1;
        end
        else if (lead_reg < LEAD4_LO)
        begin
            need = 2'd2;
        end
        else
        begin
            need = 2'd3;
        end
    end

    assign completes = ({1'b0, gathered_reg} + 3'd1) >= {1'b0, need};

    always_comb
    begin
        case (need)
            2'd1:
            begin
                full_cp = {10'd0, lead_reg[4:0], s1_byte_reg[5:0]};
                cp_ok   = full_cp >= MIN_TWO_BYTE;
            end
            2'd2:
            begin
                full_cp = {5'd0, lead_reg[3:0], cont_reg[0], s1_byte_reg[5:0]};
                cp_ok   = (full_cp >= MIN_THREE_BYTE)
                          && !((full_cp >= SURROGATE_LO) && (full_cp <= SURROGATE_HI));
            end
            default:
            begin
                full_cp = {lead_reg[2:0], cont_reg[0], cont_reg[1], s1_byte_reg[5:0]};
                cp_ok   = (full_cp >= MIN_FOUR_BYTE) && (full_cp <= MAX_SCALAR);
            end
        endcase
    end

    always_comb
    begin
        desc          = '0;
        consumed      = 1'b0;
        open_next     = open_reg;
        lead_next     = lead_reg;
        gathered_next = gathered_reg;
        cont_next     = cont_reg;

        if (open_reg)
        begin
            if (is_cont)
            begin
                consumed = 1'b1;
                if (completes)
                begin
                    if (cp_ok)
                    begin
                        desc.has_valid  = 1'b1;
                        desc.code_point = full_cp;
                        desc.byte_count = {1'b0, need} + 3'd1;
                    end
                    else
                    begin
                        desc.reps = {1'b0, need} + 3'd1;
                    end
                    open_next     = 1'b0;
                    gathered_next = 2'd0;
                end
                else
                begin
                    cont_next[gathered_reg[0]] = s1_byte_reg[5:0];
                    gathered_next = gathered_reg + 2'd1;
                end
            end
            else
            begin
                desc.reps     = {1'b0, gathered_reg} + 3'd1;
                open_next     = 1'b0;
                gathered_next = 2'd0;
            end
        end

        if (!consumed)
        begin
            if (s1_byte_reg < ASCII_LIMIT)
            begin
                desc.has_valid  = 1'b1;
                desc.code_point = {13'd0, s1_byte_reg};
                desc.byte_count = 3'd1;
            end
            else if ((s1_byte_reg < LEAD_LO) || (s1_byte_reg >= LEAD_LIMIT))
            begin
                desc.reps = desc.reps + 3'd1;
            end
            else
            begin
                lead_next     = s1_byte_reg;
                gathered_next = 2'd0;
                open_next     = 1'b1;
            end
        end

        if (s1_eot_reg && open_next)
        begin
            desc.reps     = desc.reps + {1'b0, gathered_next} + 3'd1;
            open_next     = 1'b0;
            gathered_next = 2'd0;
        end
    end

    assign desc_empty        = (desc.reps == 3'd0) && !desc.has_valid;
    assign advance           = s1_valid_reg && (desc_empty || run_free);
    assign byte_stream.ready = !s1_valid_reg || advance;
    assign run_load          = advance && !desc_empty;
    assign run_desc          = desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_stream.valid && byte_stream.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            s1_byte_reg <= byte_stream.payload.data_byte;
            s1_eot_reg  <= byte_stream.payload.end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= 1'b0;
            lead_reg     <= 8'd0;
            gathered_reg <= 2'd0;
            cont_reg[0]  <= 6'd0;
            cont_reg[1]  <= 6'd0;
        end
        else if (advance)
        begin
            open_reg     <= open_next;
            lead_reg     <= lead_next;
            gathered_reg <= gathered_next;
            cont_reg     <= cont_next;
        end
    end

endmodule

>>> rtl/usd_emit.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder result stage
// Holds one result run and presents its results one transfer at a time.
// ----------------------------------------------------------------------------
module usd_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             run_load,
    input  usd_pkg::usd_run_t run_desc,
    output logic             run_free,
    usd_stream_if.source     char_stream
);
    import usd_pkg::*;

    logic     run_valid_reg;
    usd_run_t run_reg;
    logic     is_rep;
    logic     is_last;
    logic     xfer;

    assign is_rep  = (run_reg.reps != 3'd0);
    assign is_last = (run_reg.reps == 3'd0) || ((run_reg.reps == 3'd1) && !run_reg.has_valid);
    assign xfer    = char_stream.valid && char_stream.ready;

    assign char_stream.valid               = run_valid_reg;
    assign char_stream.payload.code_point  = is_rep ? REPLACEMENT_CP : run_reg.code_point;
    assign char_stream.payload.byte_count  = is_rep ? 3'd1 : run_reg.byte_count;
    assign char_stream.payload.malformed   = is_rep;
    assign char_stream.payload.last_of_run = is_last;

    assign run_free = !run_valid_reg || (xfer && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
        end
        else if (run_free)
        begin
            run_valid_reg <= run_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_free && run_load)
        begin
            run_reg <= run_desc;
        end
        else if (xfer && is_rep)
        begin
            run_reg.reps <= run_reg.reps - 3'd1;
        end
    end

endmodule

>>> rtl/utf8_stream_decoder.sv
// A transferred byte is registered in the input stage, then its run in the
// result stage, which presents it. One byte per cycle while the result stage
// is free; a byte with k results (k up to 4) stalls the input as they drain.
// Reset (rst_n low, asynchronous) clears the input and result valid flags and
// closes any pending sequence.
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into scalar values, substituting U+FFFD for bad input.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
    input  logic         clk,
    input  logic         rst_n,
    usd_stream_if.sink   byte_stream,
    usd_stream_if.source char_stream
);
    import usd_pkg::*;

    logic     run_load;
    logic     run_free;
    usd_run_t run_desc;

    usd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .run_free    (run_free),
        .run_load    (run_load),
        .run_desc    (run_desc)
    );

    usd_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .run_load    (run_load),
        .run_desc    (run_desc),
        .run_free    (run_free),
        .char_stream (char_stream)
    );

    `USD_ASSERT_IMPLY(a_rep_form, clk, rst_n,
        char_stream.valid && char_stream.payload.malformed,
        (char_stream.payload.code_point == REPLACEMENT_CP)
        && (char_stream.payload.byte_count == 3'd1))
    `USD_ASSERT_IMPLY(a_valid_last, clk, rst_n,
        char_stream.valid && !char_stream.payload.malformed,
        char_stream.payload.last_of_run)
    `USD_ASSERT_IMPLY(a_load_nonempty, clk, rst_n,
        run_load, (run_desc.reps != 3'd0) || run_desc.has_valid)
    `USD_ASSERT_NEXT(a_load_shows, clk, rst_n,
        run_load && run_free, char_stream.valid)

endmodule
